### rtl/core/mpas_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multiprecision add/sub/mul unit.
// No dependencies; used by the top level.

package mpas_pkg;

  // Limb width and default operand size in limbs
  localparam int LIMB_W        = 32;
  localparam int NUM_LIMBS_DEF = 32;

  // Operation codes carried on the last input word
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  // Input word: one limb of each operand plus the operation
  typedef struct packed {
    logic [1:0]        operation;
    logic [LIMB_W-1:0] limb_a;
    logic [LIMB_W-1:0] limb_b;
    logic              last_limb;
  } in_word_t;

  // Output word: one limb of the result
  typedef struct packed {
    logic [LIMB_W-1:0] result_limb;
    logic              negative;
    logic              last_result;
  } out_word_t;

endpackage

### rtl/core/mpas_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered, write-first read.
// Self-contained; instantiated for the operand and result limb stores.

module mpas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read; a same-address write passes through
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/multiprecision_add_sub_mul_unit.sv
`timescale 1ns / 1ps
// Input words are taken only while idle; after the last word the unit runs
//   the add pass, the subtract compare scan and pass, or the multiply steps
//   and drain, then reads and holds each result limb before taking words again.
// The 32x32 multiplier and the one 64-bit adder are shared over all steps.
// Reset (rst_n low, synchronous) returns to idle with both operands empty.
// Depends on mpas_pkg and mpas_ram.

module multiprecision_add_sub_mul_unit #(
  parameter int NUM_LIMBS = mpas_pkg::NUM_LIMBS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpas_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mpas_pkg::out_word_t out_word
);

  localparam int LW = mpas_pkg::LIMB_W;
  localparam int IW = $clog2(NUM_LIMBS);
  localparam int CW = $clog2(NUM_LIMBS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LIMBS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_LIMBS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CMP, ST_ADDSUB, ST_MUL, ST_DRAIN, ST_OUT_RD, ST_OUT_HOLD
  } state_t;

  // Control state
  state_t         state_r, state_nxt;
  logic [CW-1:0]  load_cnt_r, load_cnt_nxt;
  logic           p_vld_r, p_vld_nxt;

  // Datapath state
  logic [1:0]     op_r, op_nxt;
  logic           neg_r, neg_nxt;
  logic           decided_r, decided_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  j_r, j_nxt;
  logic [LW-1:0]  carry_r, carry_nxt;
  logic [2*LW-1:0] prod_r, prod_nxt;
  logic [IW-1:0]  p_addr_r, p_addr_nxt;
  logic           p_first_row_r, p_first_row_nxt;
  logic           p_new_row_r, p_new_row_nxt;

  // Memory ports
  logic           in_accept;
  logic           op_we;
  logic [LW-1:0]  a_rdata, b_rdata, res_rdata;
  logic           res_we;
  logic [IW-1:0]  res_waddr, res_raddr;
  logic [LW-1:0]  res_wdata;

  // Shared arithmetic
  logic [LW-1:0]   av, bv, xv, yv;
  logic [IW-1:0]   ij_sum;
  logic [2*LW-1:0] add_x, add_y, add_sum;
  logic [LW-1:0]   add_c;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign op_we     = in_accept && (load_cnt_r < FULL_CNT);

  // Operand limbs past the loaded count read as zero
  assign av     = (CW'(i_r) < load_cnt_r) ? a_rdata : '0;
  assign bv     = (CW'(j_r) < load_cnt_r) ? b_rdata : '0;
  assign xv     = neg_r ? bv : av;
  assign yv     = neg_r ? av : bv;
  assign ij_sum = i_r + j_r;

  // Select operands of the shared adder
  always_comb begin
    if ((state_r == ST_MUL) || (state_r == ST_DRAIN)) begin
      add_x = prod_r;
      add_y = {{LW{1'b0}}, (p_first_row_r ? {LW{1'b0}} : res_rdata)};
      add_c = p_new_row_r ? '0 : carry_r;
    end else if (op_r == mpas_pkg::OP_SUB) begin
      add_x = {{LW{1'b0}}, xv};
      add_y = {{LW{1'b0}}, ~yv};
      add_c = carry_r;
    end else begin
      add_x = {{LW{1'b0}}, xv};
      add_y = {{LW{1'b0}}, yv};
      add_c = carry_r;
    end
  end

  assign add_sum = add_x + add_y + {{LW{1'b0}}, add_c};

  // Result store write port: add/sub pass or multiply accumulate stage
  always_comb begin
    if (state_r == ST_ADDSUB) begin
      res_we    = 1'b1;
      res_waddr = i_r;
    end else begin
      res_we    = p_vld_r && ((state_r == ST_MUL) || (state_r == ST_DRAIN));
      res_waddr = p_addr_r;
    end
    res_wdata = add_sum[LW-1:0];
    res_raddr = (state_r == ST_MUL) ? ij_sum : i_r;
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    load_cnt_nxt    = load_cnt_r;
    p_vld_nxt       = 1'b0;
    op_nxt          = op_r;
    neg_nxt         = neg_r;
    decided_nxt     = decided_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    carry_nxt       = carry_r;
    prod_nxt        = av * bv;
    p_addr_nxt      = ij_sum;
    p_first_row_nxt = (i_r == '0);
    p_new_row_nxt   = (j_r == '0);

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (op_we) begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
          if (in_word.last_limb) begin
            op_nxt  = in_word.operation;
            neg_nxt = 1'b0;
            unique case (in_word.operation)
              mpas_pkg::OP_ADD: begin
                state_nxt = ST_ADDSUB;
                i_nxt     = '0;
                j_nxt     = '0;
                carry_nxt = '0;
              end
              mpas_pkg::OP_SUB: begin
                state_nxt   = ST_CMP;
                i_nxt       = LAST_IDX;
                j_nxt       = LAST_IDX;
                decided_nxt = 1'b0;
              end
              mpas_pkg::OP_MUL: begin
                state_nxt = ST_MUL;
                i_nxt     = '0;
                j_nxt     = '0;
              end
              default: begin
                // Unknown operation: drop the operands, give no result
                load_cnt_nxt = '0;
              end
            endcase
          end
        end
      end

      ST_CMP: begin
        // Scan from the top limb; the first difference decides the sign
        if (!decided_r && (av != bv)) begin
          decided_nxt = 1'b1;
          neg_nxt     = (av < bv);
        end
        if (i_r == '0) begin
          state_nxt = ST_ADDSUB;
          carry_nxt = {{(LW-1){1'b0}}, 1'b1};
        end else begin
          i_nxt = i_r - 1'b1;
          j_nxt = j_r - 1'b1;
        end
      end

      ST_ADDSUB: begin
        carry_nxt = add_sum[2*LW-1:LW];
        if (i_r == LAST_IDX) begin
          state_nxt    = ST_OUT_RD;
          load_cnt_nxt = '0;
          i_nxt        = '0;
        end else begin
          i_nxt = i_r + 1'b1;
          j_nxt = j_r + 1'b1;
        end
      end

      ST_MUL: begin
        // Issue one partial product; accumulate the previous one
        p_vld_nxt = 1'b1;
        if (p_vld_r) begin
          carry_nxt = add_sum[2*LW-1:LW];
        end
        if (ij_sum == LAST_IDX) begin
          if (i_r == LAST_IDX) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = '0;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      ST_DRAIN: begin
        carry_nxt    = add_sum[2*LW-1:LW];
        state_nxt    = ST_OUT_RD;
        load_cnt_nxt = '0;
        i_nxt        = '0;
      end

      ST_OUT_RD: begin
        state_nxt = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        if (!out_stall) begin
          if (i_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      p_vld_r    <= 1'b0;
      op_r       <= mpas_pkg::OP_ADD;
      neg_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      p_vld_r    <= p_vld_nxt;
      op_r       <= op_nxt;
      neg_r      <= neg_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    decided_r     <= decided_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    carry_r       <= carry_nxt;
    prod_r        <= prod_nxt;
    p_addr_r      <= p_addr_nxt;
    p_first_row_r <= p_first_row_nxt;
    p_new_row_r   <= p_new_row_nxt;
  end

  // Operand and result limb stores
  mpas_ram #(.WIDTH(LW), .DEPTH(NUM_LIMBS)) u_a_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (load_cnt_r[IW-1:0]),
    .wdata (in_word.limb_a),
    .raddr (i_nxt),
    .rdata (a_rdata)
  );

  mpas_ram #(.WIDTH(LW), .DEPTH(NUM_LIMBS)) u_b_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (load_cnt_r[IW-1:0]),
    .wdata (in_word.limb_b),
    .raddr (j_nxt),
    .rdata (b_rdata)
  );

  mpas_ram #(.WIDTH(LW), .DEPTH(NUM_LIMBS)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  // Drive the output word straight from the registered result read
  assign out_valid = (state_r == ST_OUT_HOLD);
  always_comb begin
    out_word.result_limb = res_rdata;
    out_word.negative    = neg_r;
    out_word.last_result = (i_r == LAST_IDX);
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= FULL_CNT)
    else $error("load count past operand size");

  a_ops_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_HOLD) |-> (load_cnt_r == '0))
    else $error("operands not cleared before result output");

  a_mul_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (CW'(i_r) + CW'(j_r) < FULL_CNT))
    else $error("multiply step beyond kept limbs");

  a_neg_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.negative) |-> (op_r == mpas_pkg::OP_SUB))
    else $error("negative flag outside subtract");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_word.last_result) |=> (state_r == ST_IDLE))
    else $error("unit not idle after final result limb");

endmodule
